// ===== hdl/sstq_pkg.sv =====
// sstq_pkg: shared types, codes and sizes for the sorted software timer queue.
// No dependencies; imported by sstq_alu, sstq_list, sorted_software_timer_queue and the bench.
`timescale 1ns / 1ps

package sstq_pkg;

  // pool size and derived widths
  localparam int NUM_TIMERS = 16;
  localparam int SLOTS      = (NUM_TIMERS < 16) ? NUM_TIMERS : 16;
  localparam int PTR_W      = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int CNT_W      = $clog2(SLOTS + 1);
  localparam int ID_W       = 4;
  localparam int DL_W       = 32;
  localparam logic [DL_W-1:0] MAX_DL = {DL_W{1'b1}};

  // request codes
  localparam logic [1:0] REQ_ALLOC = 2'd0;
  localparam logic [1:0] REQ_FREE  = 2'd1;
  localparam logic [1:0] REQ_ARM   = 2'd2;
  localparam logic [1:0] REQ_TICK  = 2'd3;

  // result kinds
  localparam logic [1:0] K_ALLOC = 2'd0;
  localparam logic [1:0] K_ACK   = 2'd1;
  localparam logic [1:0] K_EXP   = 2'd2;
  localparam logic [1:0] K_TICK  = 2'd3;

  // result status
  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_NOFREE   = 2'd1;
  localparam logic [1:0] ST_NOTALLOC = 2'd2;

  // slot states
  localparam logic [1:0] SL_FREE  = 2'd0;
  localparam logic [1:0] SL_ALLOC = 2'd1;
  localparam logic [1:0] SL_ARMED = 2'd2;

  typedef struct packed {
    logic [1:0]      req_type;
    logic [ID_W-1:0] timer_id;
    logic [31:0]     delay;
    logic [7:0]      tag;
    logic [1:0]      dest_queue;
  } req_t;

  typedef struct packed {
    logic [1:0]      kind;
    logic [1:0]      status;
    logic [ID_W-1:0] timer_id_res;
    logic [7:0]      tag_res;
    logic [1:0]      dest_queue_res;
    logic            last;
  } res_t;

  // sequencer states
  typedef enum logic [2:0] {
    S_IDLE,
    S_ALLOC,
    S_FIND,
    S_ADD,
    S_INS,
    S_TICK,
    S_EXP
  } state_t;

  // list operations
  typedef enum logic [1:0] {
    L_NONE,
    L_INS,
    L_DEL
  } lop_t;

  typedef struct packed {
    lop_t             op;
    logic [PTR_W-1:0] pos;
    logic [PTR_W-1:0] id;
    logic [DL_W-1:0]  dl;
  } lcmd_t;

  typedef struct packed {
    logic [CNT_W-1:0] count;
    logic [PTR_W-1:0] rd_id;
    logic [DL_W-1:0]  rd_dl;
  } lstat_t;

  // result beat builder
  function automatic res_t mk_res(logic [1:0] kind, logic [1:0] status,
                                  logic [ID_W-1:0] id, logic [7:0] tag,
                                  logic [1:0] dest, logic last);
    res_t r;
    r.kind           = kind;
    r.status         = status;
    r.timer_id_res   = id;
    r.tag_res        = tag;
    r.dest_queue_res = dest;
    r.last           = last;
    return r;
  endfunction

endpackage

// ===== hdl/sstq_alu.sv =====
// sstq_alu: the one shared 32-bit add / compare unit of the timer queue.
// Depends on sstq_pkg.
`timescale 1ns / 1ps

module sstq_alu (
  input  logic [sstq_pkg::DL_W-1:0] a,
  input  logic [sstq_pkg::DL_W-1:0] b,
  input  logic                      sub,
  output logic [sstq_pkg::DL_W-1:0] sum,
  output logic                      carry
);
  import sstq_pkg::*;

  logic [DL_W:0] full;

  // add: carry flags overflow; subtract: carry set means a >= b
  always_comb begin
    full  = {1'b0, a} + {1'b0, (sub ? ~b : b)} + {{DL_W{1'b0}}, sub};
    sum   = full[DL_W-1:0];
    carry = full[DL_W];
  end

endmodule

// ===== hdl/sstq_list.sv =====
// sstq_list: deadline-sorted list of armed timers, one insert or delete a cycle.
// Depends on sstq_pkg.
`timescale 1ns / 1ps

module sstq_list (
  input  logic             clk,
  input  logic             rst,
  input  sstq_pkg::lcmd_t  cmd,
  output sstq_pkg::lstat_t stat
);
  import sstq_pkg::*;

  logic [PTR_W-1:0] list_id [SLOTS];
  logic [DL_W-1:0]  list_dl [SLOTS];
  logic [CNT_W-1:0] count;

  // entry shifting: insert opens a hole at pos, delete closes it
  always_ff @(posedge clk) begin
    for (int i = 0; i < SLOTS; i++) begin
      if (cmd.op == L_INS) begin
        if (i == int'(cmd.pos)) begin
          list_id[i] <= cmd.id;
          list_dl[i] <= cmd.dl;
        end else if (i > int'(cmd.pos)) begin
          list_id[i] <= list_id[i-1];
          list_dl[i] <= list_dl[i-1];
        end
      end else if (cmd.op == L_DEL) begin
        if (i >= int'(cmd.pos) && i < SLOTS - 1) begin
          list_id[i] <= list_id[i+1];
          list_dl[i] <= list_dl[i+1];
        end
      end
    end
  end

  // fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (cmd.op == L_INS) begin
      count <= count + CNT_W'(1);
    end else if (cmd.op == L_DEL) begin
      count <= count - CNT_W'(1);
    end
  end

  // single read port at the walk position
  always_comb begin
    stat.count = count;
    stat.rd_id = list_id[cmd.pos];
    stat.rd_dl = list_dl[cmd.pos];
  end

endmodule

// ===== hdl/sorted_software_timer_queue.sv =====
// sorted_software_timer_queue: top level, request sequencer and slot tables.
// Depends on sstq_pkg, sstq_alu, sstq_list.
//
//  channel  | signals                  | handshake
//  ---------+--------------------------+-----------------------------------
//  request  | start, busy, req         | beat taken when start && !busy
//  result   | result_valid, result     | one-cycle strobe, always taken
//
// Steps: alloc checks one slot per cycle; free of an unarmed slot and rejected
// requests are answered from idle; withdraw walks the list one entry per cycle
// (up to SLOTS); arm forms the deadline in the shared adder, then walks the list
// one entry per cycle (up to SLOTS), after any withdraw; tick steps the count,
// then pops the expired timers. All steps share the one 32-bit adder/comparator.
// Reset is synchronous and clears slot states, list count and tick count.
// The receiver cannot stall: each result is shown for exactly one cycle.
`timescale 1ns / 1ps

module sorted_software_timer_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           start,
  output logic           busy,
  input  sstq_pkg::req_t req,
  output logic           result_valid,
  output sstq_pkg::res_t result
);
  import sstq_pkg::*;

  localparam logic [ID_W:0] SLOTS_V = (ID_W + 1)'(SLOTS);

  state_t           state, state_next;
  logic [PTR_W-1:0] ptr, ptr_next;
  req_t             req_q;
  logic [DL_W-1:0]  tick, dl, dl_next;

  logic [1:0]       slot_state [SLOTS];
  logic [7:0]       slot_tag   [SLOTS];
  logic [1:0]       slot_dest  [SLOTS];

  logic             st_we, tag_we, tick_we;
  logic [PTR_W-1:0] st_idx, sidx, qidx, ridx;
  logic [1:0]       st_val, sst;
  logic             id_ok;

  logic [DL_W-1:0]  alu_a, alu_b, alu_sum;
  logic             alu_sub, alu_carry;

  lcmd_t            lcmd;
  lstat_t           lstat;

  res_t             res_next;
  logic             res_vld_next;

  sstq_alu u_alu (
    .a     (alu_a),
    .b     (alu_b),
    .sub   (alu_sub),
    .sum   (alu_sum),
    .carry (alu_carry)
  );

  sstq_list u_list (
    .clk  (clk),
    .rst  (rst),
    .cmd  (lcmd),
    .stat (lstat)
  );

  // slot state read address: request id while idle, scan pointer otherwise
  assign id_ok = {1'b0, req.timer_id} < SLOTS_V;
  assign qidx  = req_q.timer_id[PTR_W-1:0];
  assign sidx  = (state == S_IDLE) ? req.timer_id[PTR_W-1:0] : ptr;
  assign sst   = slot_state[sidx];
  assign ridx  = lstat.rd_id;
  assign busy  = (state != S_IDLE);

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // sequencer
  always_comb begin
    state_next   = state;
    ptr_next     = ptr;
    dl_next      = dl;
    res_next     = mk_res(K_TICK, ST_OK, '0, '0, '0, 1'b1);
    res_vld_next = 1'b0;
    st_we        = 1'b0;
    st_idx       = qidx;
    st_val       = SL_FREE;
    tag_we       = 1'b0;
    tick_we      = 1'b0;
    alu_a        = tick;
    alu_b        = req_q.delay;
    alu_sub      = 1'b0;
    lcmd.op      = L_NONE;
    lcmd.pos     = ptr;
    lcmd.id      = qidx;
    lcmd.dl      = dl;
    case (state)
      S_IDLE: begin
        ptr_next = '0;
        if (start) begin
          case (req.req_type)
            REQ_ALLOC: state_next = S_ALLOC;
            REQ_FREE: begin
              if (!id_ok) begin
                res_next     = mk_res(K_ACK, ST_NOTALLOC, req.timer_id, '0, '0, 1'b1);
                res_vld_next = 1'b1;
              end else if (sst == SL_ARMED) begin
                state_next = S_FIND;
              end else begin
                st_we        = 1'b1;
                st_idx       = req.timer_id[PTR_W-1:0];
                st_val       = SL_FREE;
                res_next     = mk_res(K_ACK, ST_OK, req.timer_id, '0, '0, 1'b1);
                res_vld_next = 1'b1;
              end
            end
            REQ_ARM: begin
              if (!id_ok || sst == SL_FREE) begin
                res_next     = mk_res(K_ACK, ST_NOTALLOC, req.timer_id, '0, '0, 1'b1);
                res_vld_next = 1'b1;
              end else if (sst == SL_ARMED) begin
                state_next = S_FIND;
              end else begin
                state_next = S_ADD;
              end
            end
            default: state_next = S_TICK;
          endcase
        end
      end
      // first free slot, one per cycle
      S_ALLOC: begin
        if (sst == SL_FREE) begin
          st_we        = 1'b1;
          st_idx       = ptr;
          st_val       = SL_ALLOC;
          res_next     = mk_res(K_ALLOC, ST_OK, ID_W'(ptr), '0, '0, 1'b1);
          res_vld_next = 1'b1;
          state_next   = S_IDLE;
        end else if (ptr == PTR_W'(SLOTS - 1)) begin
          res_next     = mk_res(K_ALLOC, ST_NOFREE, '0, '0, '0, 1'b1);
          res_vld_next = 1'b1;
          state_next   = S_IDLE;
        end else begin
          ptr_next = ptr + PTR_W'(1);
        end
      end
      // withdraw an armed timer from the list
      S_FIND: begin
        if (lstat.count == CNT_W'(ptr) || ridx == qidx) begin
          if (lstat.count != CNT_W'(ptr)) begin
            lcmd.op = L_DEL;
          end
          ptr_next = '0;
          if (req_q.req_type == REQ_FREE) begin
            st_we        = 1'b1;
            st_val       = SL_FREE;
            res_next     = mk_res(K_ACK, ST_OK, req_q.timer_id, '0, '0, 1'b1);
            res_vld_next = 1'b1;
            state_next   = S_IDLE;
          end else begin
            state_next = S_ADD;
          end
        end else begin
          ptr_next = ptr + PTR_W'(1);
        end
      end
      // deadline = tick + delay, saturating
      S_ADD: begin
        dl_next    = alu_carry ? MAX_DL : alu_sum;
        ptr_next   = '0;
        state_next = S_INS;
      end
      // walk to the first entry with deadline >= new deadline
      S_INS: begin
        alu_a   = lstat.rd_dl;
        alu_b   = dl;
        alu_sub = 1'b1;
        if (lstat.count == CNT_W'(ptr) || alu_carry) begin
          lcmd.op      = L_INS;
          st_we        = 1'b1;
          st_val       = SL_ARMED;
          tag_we       = 1'b1;
          res_next     = mk_res(K_ACK, ST_OK, req_q.timer_id, '0, '0, 1'b1);
          res_vld_next = 1'b1;
          state_next   = S_IDLE;
        end else begin
          ptr_next = ptr + PTR_W'(1);
        end
      end
      S_TICK: begin
        alu_b      = DL_W'(1);
        tick_we    = 1'b1;
        ptr_next   = '0;
        state_next = S_EXP;
      end
      // pop expired timers from the head, one per cycle
      S_EXP: begin
        alu_a   = tick;
        alu_b   = lstat.rd_dl;
        alu_sub = 1'b1;
        if (lstat.count != '0 && alu_carry) begin
          lcmd.op      = L_DEL;
          st_we        = 1'b1;
          st_idx       = ridx;
          st_val       = SL_ALLOC;
          res_next     = mk_res(K_EXP, ST_OK, ID_W'(ridx), slot_tag[ridx],
                                slot_dest[ridx], 1'b0);
          res_vld_next = 1'b1;
        end else begin
          res_vld_next = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
      tick         <= '0;
      for (int i = 0; i < SLOTS; i++) begin
        slot_state[i] <= SL_FREE;
      end
    end else begin
      result_valid <= res_vld_next;
      if (tick_we) begin
        tick <= alu_sum;
      end
      if (st_we) begin
        slot_state[st_idx] <= st_val;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    result <= res_next;
    ptr    <= ptr_next;
    dl     <= dl_next;
    if (start && !busy) begin
      req_q <= req;
    end
    if (tag_we) begin
      slot_tag[qidx]  <= req_q.tag;
      slot_dest[qidx] <= req_q.dest_queue;
    end
  end

  // checks
  a_tick_last: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.kind == K_TICK |-> result.last)
    else $error("tick done beat without last");

  a_exp_not_last: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.kind == K_EXP |-> !result.last)
    else $error("expiry beat marked last");

  a_busy_start: assert property (@(posedge clk) disable iff (rst)
    $rose(busy) |-> $past(start))
    else $error("busy rose without a request");

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    lstat.count <= CNT_W'(SLOTS))
    else $error("list count beyond pool size");

endmodule

// ===== tb/sorted_software_timer_queue_tb.sv =====
// sorted_software_timer_queue_tb: self-checking bench for the timer queue. A
// class-based scoreboard predicts results. Depends on sstq_pkg and the
// sorted_software_timer_queue top level.
`timescale 1ns / 1ps

module sorted_software_timer_queue_tb;
  import sstq_pkg::*;

  // Predicts the result beats of each accepted request and checks them in order
  class timer_queue_scoreboard;
    logic [1:0]      slot_state    [SLOTS];
    logic [DL_W-1:0] slot_deadline [SLOTS];
    logic [7:0]      slot_tag      [SLOTS];
    logic [1:0]      slot_dest     [SLOTS];
    int unsigned     armed_order[$];
    logic [DL_W-1:0] tick_count;
    res_t            pending[$];
    int unsigned     errors;
    int unsigned     req_seen [4];
    int unsigned     expired;
    int unsigned     no_free;
    int unsigned     rejected;

    function new();
      for (int i = 0; i < SLOTS; i++) begin
        slot_state[i]    = SL_FREE;
        slot_deadline[i] = '0;
        slot_tag[i]      = '0;
        slot_dest[i]     = '0;
      end
      tick_count = '0;
      errors     = 0;
      expired    = 0;
      no_free    = 0;
      rejected   = 0;
      for (int i = 0; i < 4; i++) req_seen[i] = 0;
    endfunction

    function void add_expect(logic [1:0] kind, logic [1:0] status, logic [ID_W-1:0] id,
                             logic [7:0] tag, logic [1:0] dest, logic last);
      res_t e;
      e.kind           = kind;
      e.status         = status;
      e.timer_id_res   = id;
      e.tag_res        = tag;
      e.dest_queue_res = dest;
      e.last           = last;
      pending.push_back(e);
    endfunction

    // drop a slot from the deadline list if it is there
    function void withdraw(int unsigned id);
      for (int i = 0; i < armed_order.size(); i++) begin
        if (armed_order[i] == id) begin
          armed_order.delete(i);
          break;
        end
      end
    endfunction

    // goes in before the first entry with an equal or later deadline
    function void insert_sorted(int unsigned id);
      int pos;
      pos = 0;
      while (pos < armed_order.size() && slot_deadline[armed_order[pos]] < slot_deadline[id])
        pos++;
      armed_order.insert(pos, id);
    endfunction

    function void note_request(req_t r);
      logic [DL_W:0] sum;
      bit            found;
      int unsigned   s;
      req_seen[r.req_type]++;
      case (r.req_type)
        REQ_ALLOC: begin
          found = 0;
          for (int i = 0; i < SLOTS; i++) begin
            if (!found && slot_state[i] == SL_FREE) begin
              slot_state[i] = SL_ALLOC;
              add_expect(K_ALLOC, ST_OK, ID_W'(i), '0, '0, 1'b1);
              found = 1;
            end
          end
          if (!found) begin
            no_free++;
            add_expect(K_ALLOC, ST_NOFREE, '0, '0, '0, 1'b1);
          end
        end
        REQ_FREE: begin
          if (r.timer_id >= SLOTS) begin
            rejected++;
            add_expect(K_ACK, ST_NOTALLOC, r.timer_id, '0, '0, 1'b1);
          end else begin
            if (slot_state[r.timer_id] == SL_ARMED) withdraw(32'(r.timer_id));
            slot_state[r.timer_id] = SL_FREE;
            add_expect(K_ACK, ST_OK, r.timer_id, '0, '0, 1'b1);
          end
        end
        REQ_ARM: begin
          if (r.timer_id >= SLOTS || slot_state[r.timer_id] == SL_FREE) begin
            rejected++;
            add_expect(K_ACK, ST_NOTALLOC, r.timer_id, '0, '0, 1'b1);
          end else begin
            if (slot_state[r.timer_id] == SL_ARMED) withdraw(32'(r.timer_id));
            // deadline saturates instead of wrapping
            sum = {1'b0, tick_count} + {1'b0, r.delay};
            slot_deadline[r.timer_id] = sum[DL_W] ? MAX_DL : sum[DL_W-1:0];
            slot_tag[r.timer_id]      = r.tag;
            slot_dest[r.timer_id]     = r.dest_queue;
            slot_state[r.timer_id]    = SL_ARMED;
            insert_sorted(32'(r.timer_id));
            add_expect(K_ACK, ST_OK, r.timer_id, '0, '0, 1'b1);
          end
        end
        default: begin
          // tick: every due timer leaves in list order, then tick done
          tick_count = tick_count + DL_W'(1);
          while (armed_order.size() > 0 && slot_deadline[armed_order[0]] <= tick_count) begin
            s = armed_order.pop_front();
            slot_state[s] = SL_ALLOC;
            expired++;
            add_expect(K_EXP, ST_OK, ID_W'(s), slot_tag[s], slot_dest[s], 1'b0);
          end
          add_expect(K_TICK, ST_OK, '0, '0, '0, 1'b1);
        end
      endcase
    endfunction

    function void check_result(res_t got);
      res_t e;
      if (pending.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("ERROR %0t: extra beat kind=%0d status=%0d id=%0d tag=%h dest=%0d last=%0b",
                   $time, got.kind, got.status, got.timer_id_res, got.tag_res,
                   got.dest_queue_res, got.last);
        return;
      end
      e = pending.pop_front();
      if (got.kind !== e.kind || got.status !== e.status ||
          got.timer_id_res !== e.timer_id_res || got.tag_res !== e.tag_res ||
          got.dest_queue_res !== e.dest_queue_res || got.last !== e.last) begin
        errors++;
        if (errors <= 10) begin
          $display("ERROR %0t: exp kind=%0d status=%0d id=%0d tag=%h dest=%0d last=%0b",
                   $time, e.kind, e.status, e.timer_id_res, e.tag_res,
                   e.dest_queue_res, e.last);
          $display("         got kind=%0d status=%0d id=%0d tag=%h dest=%0d last=%0b",
                   got.kind, got.status, got.timer_id_res, got.tag_res,
                   got.dest_queue_res, got.last);
        end
      end
    endfunction
  endclass

  logic clk;
  logic rst;
  logic start;
  logic busy;
  req_t req;
  logic result_valid;
  res_t result;

  timer_queue_scoreboard sb;

  sorted_software_timer_queue DUT (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .req          (req),
    .result_valid (result_valid),
    .result       (result)
  );

  // 2 ns clock
  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // watchdog
  initial begin
    #2000000;
    $display("sorted_software_timer_queue: mismatch");
    $finish;
  end

  // sample request and result beats at the rising edge
  always @(posedge clk) begin
    if (!rst) begin
      if (start && !busy) sb.note_request(req);
      if (result_valid) sb.check_result(result);
    end
  end

  function automatic req_t beat(logic [1:0] kind, logic [ID_W-1:0] id, logic [31:0] delay,
                                logic [7:0] tag, logic [1:0] dest);
    req_t r;
    r.req_type   = kind;
    r.timer_id   = id;
    r.delay      = delay;
    r.tag        = tag;
    r.dest_queue = dest;
    return r;
  endfunction

  // mostly short gaps, a few long ones
  function automatic int unsigned pick_gap(bit quiet);
    int unsigned p;
    if (quiet) return 0;
    p = $urandom_range(0, 99);
    if (p < 55) return 0;
    if (p < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // small delays dominate so timers actually expire
  function automatic logic [31:0] pick_delay();
    int unsigned p;
    p = $urandom_range(0, 99);
    if (p < 5) return '0;
    if (p < 55) return $urandom_range(0, 8);
    if (p < 80) return $urandom_range(0, 40);
    if (p < 90) return $urandom;
    return 32'hffff_ffff - $urandom_range(0, 3);
  endfunction

  // usually an allocated or armed slot, sometimes any slot
  function automatic logic [ID_W-1:0] pick_slot();
    int unsigned used[$];
    for (int i = 0; i < SLOTS; i++)
      if (sb.slot_state[i] != SL_FREE) used.push_back(i);
    if (used.size() > 0 && $urandom_range(0, 99) < 80)
      return ID_W'(used[$urandom_range(0, used.size() - 1)]);
    return ID_W'($urandom_range(0, 15));
  endfunction

  // present one request beat, hold it until taken; returns at a falling edge
  task automatic send_beat(req_t r, int unsigned gap);
    if (gap != 0) begin
      start = 1'b0;
      repeat (gap) @(negedge clk);
    end
    start = 1'b1;
    req   = r;
    @(posedge clk);
    while (busy) @(posedge clk);
    @(negedge clk);
  endtask

  initial begin
    req_t        r;
    int unsigned mode;
    int unsigned p;
    bit          quiet;
    int unsigned waited;

    sb    = new();
    rst   = 1'b1;
    start = 1'b0;
    req   = '0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // directed: empty tick, rejects, saturation, equal deadlines, re-arm, multi-expiry
    send_beat(beat(REQ_TICK, 4'd0, 32'd0, 8'h00, 2'd0), 0);
    send_beat(beat(REQ_ALLOC, 4'd0, 32'd0, 8'h00, 2'd0), 0);
    send_beat(beat(REQ_ALLOC, 4'd0, 32'd0, 8'h00, 2'd0), 0);
    send_beat(beat(REQ_ALLOC, 4'd0, 32'd0, 8'h00, 2'd0), 1);
    send_beat(beat(REQ_ARM, 4'd5, 32'd4, 8'h11, 2'd1), 0);
    send_beat(beat(REQ_FREE, 4'd7, 32'd0, 8'h00, 2'd0), 0);
    send_beat(beat(REQ_ARM, 4'd0, 32'd0, 8'hff, 2'd3), 0);
    send_beat(beat(REQ_ARM, 4'd1, 32'hffff_ffff, 8'h00, 2'd0), 2);
    send_beat(beat(REQ_ARM, 4'd2, 32'd0, 8'ha5, 2'd2), 0);
    send_beat(beat(REQ_TICK, 4'd0, 32'd0, 8'h00, 2'd0), 0);
    send_beat(beat(REQ_ARM, 4'd0, 32'd3, 8'h5a, 2'd1), 0);
    send_beat(beat(REQ_ARM, 4'd0, 32'd1, 8'h3c, 2'd2), 0);
    send_beat(beat(REQ_ARM, 4'd2, 32'd2, 8'hc3, 2'd3), 0);
    send_beat(beat(REQ_FREE, 4'd2, 32'd0, 8'h00, 2'd0), 0);
    send_beat(beat(REQ_ARM, 4'd2, 32'd1, 8'h77, 2'd0), 0);
    send_beat(beat(REQ_TICK, 4'd0, 32'd0, 8'h00, 2'd0), 5);
    send_beat(beat(REQ_FREE, 4'd1, 32'd0, 8'h00, 2'd0), 0);
    send_beat(beat(REQ_ARM, 4'd15, 32'h8000_0000, 8'h80, 2'd2), 0);
    send_beat(beat(REQ_ALLOC, 4'd0, 32'd0, 8'h00, 2'd0), 0);
    send_beat(beat(REQ_ARM, 4'd1, 32'h7fff_ffff, 8'h81, 2'd1), 0);
    send_beat(beat(REQ_ARM, 4'd0, 32'hffff_fffc, 8'h42, 2'd3), 0);
    send_beat(beat(REQ_ALLOC, 4'd0, 32'd0, 8'h00, 2'd0), 0);
    send_beat(beat(REQ_ARM, 4'd2, 32'hffff_fffd, 8'h24, 2'd1), 0);
    send_beat(beat(REQ_TICK, 4'd0, 32'd0, 8'h00, 2'd0), 0);

    // random: segments that fill, churn or drain the pool
    for (int seg = 0; seg < 10; seg++) begin
      mode  = $urandom_range(0, 2);
      quiet = ($urandom_range(0, 2) == 0);
      for (int n = 0; n < 41; n++) begin
        p = $urandom_range(0, 99);
        case (mode)
          0:       r.req_type = (p < 50) ? REQ_ALLOC : (p < 80) ? REQ_ARM :
                                (p < 95) ? REQ_TICK : REQ_FREE;
          1:       r.req_type = (p < 15) ? REQ_ALLOC : (p < 30) ? REQ_FREE :
                                (p < 70) ? REQ_ARM : REQ_TICK;
          default: r.req_type = (p < 5) ? REQ_ALLOC : (p < 35) ? REQ_FREE :
                                (p < 50) ? REQ_ARM : REQ_TICK;
        endcase
        r.timer_id   = pick_slot();
        r.delay      = pick_delay();
        r.tag        = 8'($urandom_range(0, 255));
        r.dest_queue = 2'($urandom_range(0, 3));
        send_beat(r, pick_gap(quiet));
      end
    end
    start = 1'b0;

    // drain outstanding results, then allow for trailing beats
    waited = 0;
    while (sb.pending.size() != 0 && waited < 10000) begin
      @(posedge clk);
      waited++;
    end
    repeat (40) @(posedge clk);

    $display("Requests: %0d alloc, %0d free, %0d arm, %0d tick; %0d expiries delivered.",
             sb.req_seen[REQ_ALLOC], sb.req_seen[REQ_FREE], sb.req_seen[REQ_ARM],
             sb.req_seen[REQ_TICK], sb.expired);
    $display("Pool-full replies: %0d, rejected arms: %0d, errors: %0d, left over: %0d.",
             sb.no_free, sb.rejected, sb.errors, sb.pending.size());
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("sorted_software_timer_queue: match");
    end else begin
      $display("sorted_software_timer_queue: mismatch");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
hdl/sstq_pkg.sv
hdl/sstq_alu.sv
hdl/sstq_list.sv
hdl/sorted_software_timer_queue.sv
tb/sorted_software_timer_queue_tb.sv
